/* hw/rtl/gom_pkg.sv */
// Shared types and constants for the glyph outline marker.
// No dependencies; imported by the interfaces, the top level and the checker.
package gom_pkg;

  localparam int unsigned ROW_W     = 64;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] MAX_GLYPH   = 7'd64;
  localparam logic [CFG_W-1:0] OUTLINE_MIN = 7'd32;
  localparam logic [CFG_W-1:0] HEIGHT_RST  = 7'd32;
  localparam logic [CFG_W-1:0] WIDTH_RST   = 7'd32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 1'd1;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    row_t             core_bits;
    row_t             edge_bits;
    logic [IDX_W-1:0] row_index;
    logic             last_row;
  } res_t;

endpackage

/* hw/rtl/gom_if.sv */
// Valid/ready channels for glyph rows and classified result rows.
// Depends on gom_pkg.
interface gom_row_if;
  import gom_pkg::*;
  logic valid;
  logic ready;
  row_t row_bits;
  modport source (output valid, output row_bits, input ready);
  modport sink (input valid, input row_bits, output ready);
endinterface

interface gom_res_if;
  import gom_pkg::*;
  logic             valid;
  logic             ready;
  row_t             core_bits;
  row_t             edge_bits;
  logic [IDX_W-1:0] row_index;
  logic             last_row;
  modport source (output valid, output core_bits, output edge_bits, output row_index,
                  output last_row, input ready);
  modport sink (input valid, input core_bits, input edge_bits, input row_index,
                input last_row, output ready);
endinterface

/* hw/rtl/glyph_outline_marker_unit.sv */
// Glyph outline marker: 3x3 neighbourhood classification of a glyph bitmap.
// Depends on gom_pkg and the channel interfaces in gom_if.sv.
//
// Usage:
//   rows    : one glyph row per word, column i at bit i, top row first.
//   results : one classified row per word (core/edge masks, row index, last
//             flag). Row k is emitted when row k+1 arrives; a final row with
//             a row above it emits two words, the row above and then itself.
//   cfg     : glyph_height / glyph_width writes, only while the block is idle.
// Queueing: the words of an accepted row are registered into the queue
//   together; a word shows on results once it reaches the queue head.
// Throughput: one row per cycle. Classification is a single combinational
//   pass between the held rows and a 4-word result queue; rows are accepted
//   while the queue has room for two words, so the result side sets the pace
//   (a glyph of H rows gives H words).
// Reset: clears the held rows, the row counter and the queue, and loads
//   height 32 and width 32.
// Stall: words wait in the queue; rows keep flowing until fewer than two free
//   slots remain, then rows.ready drops until the receiver drains a word.
module glyph_outline_marker_unit (
  input  logic                              clk,
  input  logic                              rst,
  gom_row_if.sink                           rows,
  gom_res_if.source                         results,
  input  logic                              cfg_wr_en,
  input  logic [gom_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gom_pkg::CFG_W-1:0]         cfg_data
);
  import gom_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  logic [CFG_W-1:0] glyph_height;
  logic [CFG_W-1:0] glyph_width;
  row_t             upper_row;
  row_t             middle_row;
  logic [IDX_W-1:0] rows_seen;

  res_t              queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  logic [CFG_W-1:0] h_eff;
  logic [CFG_W-1:0] w_eff;
  row_t             wmask;
  row_t             side_border;
  logic             outline;
  logic             is_last;
  logic             has_prev;
  row_t             row_m;
  row_t             up_last;
  res_t             res_prev;
  res_t             res_final;
  res_t             ent_a;
  logic [1:0]       push_cnt;
  logic             accept;
  logic             pop;

  function automatic res_t classify(row_t up, row_t mid, row_t down, logic [IDX_W-1:0] r,
                                    logic last, logic mode, row_t wm, row_t side);
    res_t o;
    row_t v;
    row_t nb;
    row_t border;
    v = up | mid | down;
    nb = (v | (v << 1) | (v >> 1)) & wm;
    border = (r == '0 || last) ? wm : side;
    if (mode) begin
      o.edge_bits = (nb & ~mid & wm) | (mid & border);
      o.core_bits = mid & ~border & wm;
    end else begin
      o.edge_bits = '0;
      o.core_bits = mid & wm;
    end
    o.row_index = r;
    o.last_row  = last;
    return o;
  endfunction

  // effective geometry
  always_comb begin
    if (glyph_height == '0) begin
      h_eff = 7'd1;
    end else if (glyph_height > MAX_GLYPH) begin
      h_eff = MAX_GLYPH;
    end else begin
      h_eff = glyph_height;
    end
    w_eff = (glyph_width > MAX_GLYPH) ? MAX_GLYPH : glyph_width;
    for (int i = 0; i < ROW_W; i++) begin
      wmask[i]       = CFG_W'(i) < w_eff;
      side_border[i] = (w_eff != '0) && (i == 0 || CFG_W'(i) == w_eff - 7'd1);
    end
  end

  assign outline  = h_eff >= OUTLINE_MIN;
  assign is_last  = ({1'b0, rows_seen} + 7'd1) >= h_eff;
  assign has_prev = rows_seen != '0;
  assign row_m    = rows.row_bits & wmask;
  assign up_last  = has_prev ? middle_row : '0;

  always_comb begin
    res_prev  = classify(upper_row, middle_row, row_m, rows_seen - 6'd1, 1'b0,
                         outline, wmask, side_border);
    res_final = classify(up_last, row_m, '0, rows_seen, 1'b1,
                         outline, wmask, side_border);
    ent_a     = has_prev ? res_prev : res_final;
    push_cnt  = {1'b0, has_prev} + {1'b0, is_last};
  end

  assign rows.ready    = count <= 3'd2;
  assign accept        = rows.valid && rows.ready;
  assign results.valid = count != '0;
  assign pop           = results.valid && results.ready;

  assign results.core_bits = queue[rd_ptr].core_bits;
  assign results.edge_bits = queue[rd_ptr].edge_bits;
  assign results.row_index = queue[rd_ptr].row_index;
  assign results.last_row  = queue[rd_ptr].last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_height <= HEIGHT_RST;
      glyph_width  <= WIDTH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GLYPH_HEIGHT: glyph_height <= cfg_data;
        REG_GLYPH_WIDTH:  glyph_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row  <= '0;
      middle_row <= '0;
      rows_seen  <= '0;
    end else if (accept) begin
      if (is_last) begin
        upper_row  <= '0;
        middle_row <= '0;
        rows_seen  <= '0;
      end else begin
        upper_row  <= up_last;
        middle_row <= row_m;
        rows_seen  <= rows_seen + 6'd1;
      end
    end
  end

  // result queue payload; a final row with a predecessor writes two slots
  always_ff @(posedge clk) begin
    if (accept && push_cnt != 2'd0) begin
      queue[wr_ptr] <= ent_a;
    end
    if (accept && push_cnt == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + push_cnt;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (accept ? {1'b0, push_cnt} : 3'd0) - {2'b0, pop};
    end
  end

endmodule

/* hw/rtl/gom_checker.sv */
// Port-level checks for glyph_outline_marker_unit, attached by bind.
// Depends on gom_pkg.
module gom_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     rows_valid,
  input logic                     rows_ready,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic [gom_pkg::ROW_W-1:0] core_bits,
  input logic [gom_pkg::ROW_W-1:0] edge_bits,
  input logic [gom_pkg::IDX_W-1:0] row_index,
  input logic                     last_row
);
  import gom_pkg::*;

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(core_bits) && $stable(edge_bits)
      && $stable(row_index) && $stable(last_row))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // input backpressure only comes from a result backlog
  a_ready_backlog: assert property (@(posedge clk) disable iff (rst)
    !rows_ready |-> res_valid)
    else $error("rows stalled with no pending results");

  // an empty queue always has room for a final row's two words
  a_room_after_empty: assert property (@(posedge clk) disable iff (rst)
    !$past(res_valid) |-> rows_ready)
    else $error("rows stalled one cycle after empty queue");

endmodule

bind glyph_outline_marker_unit gom_checker u_gom_checker (
  .clk        (clk),
  .rst        (rst),
  .rows_valid (rows.valid),
  .rows_ready (rows.ready),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .core_bits  (results.core_bits),
  .edge_bits  (results.edge_bits),
  .row_index  (results.row_index),
  .last_row   (results.last_row)
);
